>>> sv/mtl_pkg.sv
package mtl_pkg;

    localparam int MAX_EDGE     = 2048;
    localparam int MAX_LEVELS   = 12;
    localparam int ALIGN_TEXELS = 4;
    localparam int ALIGN_ROWS   = 2;
    localparam int PITCH_ALIGN  = 64;

    // field widths
    localparam int EDGE_IN_W = 16;
    localparam int LVL_W     = 4;
    localparam int OFF_W     = 25;
    localparam int PITCH_W   = 14;
    localparam int ROWS_W    = 13;

    // texel edges that survive validation fit here
    localparam int EDGE_W = $clog2(MAX_EDGE) + 1;
    // running row position and row sums
    localparam int Y_W    = ROWS_W + 1;
    localparam int PROD_W = Y_W + PITCH_W;

    typedef struct packed {
        logic [EDGE_IN_W-1:0] map_width;
        logic [EDGE_IN_W-1:0] map_height;
        logic [LVL_W-1:0]     level_count;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [LVL_W-1:0]   level_index;
        logic [OFF_W-1:0]   level_byte_offset;
        logic [PITCH_W-1:0] row_pitch;
        logic [ROWS_W-1:0]  total_rows;
        logic               last;
    } t_res;

    // microprogram
    localparam int STEP_W = 2;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_LEVEL  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_REFUSE = 2'd3;

    typedef enum logic [1:0] {
        JC_ALWAYS,
        JC_IN_VALID,
        JC_REQ_OK,
        JC_MORE
    } t_jcond;

    typedef struct packed {
        logic              take_in;
        logic              setup;
        logic              emit_lvl;
        logic              emit_ref;
        t_jcond            jcond;
        logic [STEP_W-1:0] j_true;
        logic [STEP_W-1:0] j_false;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic req_ok;
        logic more;
        logic out_free;
    } t_cond;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] pc);
        t_ctrl c;
        unique case (pc)
            STEP_WAIT:   c = '{1'b1, 1'b0, 1'b0, 1'b0, JC_IN_VALID, STEP_CHECK, STEP_WAIT};
            STEP_CHECK:  c = '{1'b0, 1'b1, 1'b0, 1'b0, JC_REQ_OK, STEP_LEVEL, STEP_REFUSE};
            STEP_LEVEL:  c = '{1'b0, 1'b0, 1'b1, 1'b0, JC_MORE, STEP_LEVEL, STEP_WAIT};
            STEP_REFUSE: c = '{1'b0, 1'b0, 1'b0, 1'b1, JC_ALWAYS, STEP_WAIT, STEP_WAIT};
        endcase
        return c;
    endfunction

    function automatic logic edge_ok(input logic [EDGE_IN_W-1:0] e);
        return (e != '0) && (e <= EDGE_IN_W'(MAX_EDGE)) && ((e & (e - 1'b1)) == '0);
    endfunction

endpackage

>>> sv/mtl_stream_if.sv
interface mtl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/mtl_seq.sv
module mtl_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mtl_pkg::t_cond i_cond,
    output mtl_pkg::t_ctrl o_ctrl,
    output logic           o_go
);

    logic [mtl_pkg::STEP_W-1:0] r_pc;
    logic [mtl_pkg::STEP_W-1:0] n_pc;
    logic                       hit;

    assign o_ctrl = mtl_pkg::ucode(r_pc);
    // hold an emit step while the output register is still full
    assign o_go   = !((o_ctrl.emit_lvl || o_ctrl.emit_ref) && !i_cond.out_free);

    always_comb begin
        unique case (o_ctrl.jcond)
            mtl_pkg::JC_ALWAYS:   hit = 1'b1;
            mtl_pkg::JC_IN_VALID: hit = i_cond.in_valid;
            mtl_pkg::JC_REQ_OK:   hit = i_cond.req_ok;
            mtl_pkg::JC_MORE:     hit = i_cond.more;
        endcase
        if (!o_go) begin
            n_pc = r_pc;
        end else begin
            n_pc = hit ? o_ctrl.j_true : o_ctrl.j_false;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mtl_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> sv/mipmap_tree_layout_top.sv
// Channel   Dir  Payload                                            Transfer
// i_req     in   map_width, map_height, level_count                  valid & ready
// o_res     out  ok, level_index, level_byte_offset, row_pitch,      valid & ready
//                total_rows, last
//
// A valid request is taken in the wait step and checked in the check step, which forms
// the pitch; the level step then emits each level in turn, with a shared multiply-add for
// the offset. A refused request passes the wait, check and refuse steps; it gives one item.
// Reset is synchronous; it clears the step counter and the output valid only.
// Results pass through one output register; a stalled output holds the level or refuse step.
module mipmap_tree_layout_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtl_stream_if.sink    i_req,
    mtl_stream_if.source  o_res
);

    localparam int EW = mtl_pkg::EDGE_W;
    localparam int YW = mtl_pkg::Y_W;
    localparam int PW = mtl_pkg::PITCH_W;
    localparam int LW = mtl_pkg::LVL_W;

    mtl_pkg::t_ctrl ctrl;
    mtl_pkg::t_cond cond;
    logic           seq_go;

    logic [mtl_pkg::EDGE_IN_W-1:0] r_w;
    logic [mtl_pkg::EDGE_IN_W-1:0] r_h;
    logic [LW-1:0]                 r_n;
    logic [PW-1:0]                 r_pitch;
    logic [YW-1:0]                 r_x;
    logic [YW-1:0]                 r_y;
    logic [YW-1:0]                 r_total;
    logic [LW-1:0]                 r_lvl;
    logic [EW-1:0]                 r_ch;
    logic                          r_out_valid;
    mtl_pkg::t_res                 r_out;

    logic [4:0]                    lvl_cap;
    logic [mtl_pkg::EDGE_IN_W-1:0] big_edge;
    logic                          req_ok;
    logic [EW-1:0]                 w_e;
    logic [EW-1:0]                 half1;
    logic [EW-1:0]                 half2;
    logic [YW-1:0]                 x_side;
    logic [YW-1:0]                 side;
    logic [YW-1:0]                 width_span;
    logic [PW-1:0]                 pitch;
    logic [YW-1:0]                 rows;
    logic [YW-1:0]                 y_end;
    logic [YW-1:0]                 tot_next;
    logic [mtl_pkg::PROD_W-1:0]    prod;
    logic [mtl_pkg::PROD_W-1:0]    offset;
    logic                          is_last;
    logic                          out_free;
    logic                          fire_lvl;
    logic                          fire_ref;

    mtl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl),
        .o_go    (seq_go)
    );

    // validation
    always_comb begin
        big_edge = (r_w > r_h) ? r_w : r_h;
        lvl_cap  = 5'd1;
        for (int i = 1; i < mtl_pkg::EDGE_IN_W; i++) begin
            if (big_edge[i]) begin
                lvl_cap = 5'(i + 1);
            end
        end
        req_ok = mtl_pkg::edge_ok(r_w) && mtl_pkg::edge_ok(r_h) && (r_n != '0)
              && (5'(r_n) <= lvl_cap) && (r_n <= LW'(mtl_pkg::MAX_LEVELS));
    end

    // pitch and the column offset for levels after level 1
    always_comb begin
        w_e        = r_w[EW-1:0];
        half1      = (w_e > EW'(1)) ? (w_e >> 1) : EW'(1);
        half2      = (w_e > EW'(3)) ? (w_e >> 2) : EW'(1);
        x_side     = (YW'(half1) + YW'(mtl_pkg::ALIGN_TEXELS - 1))
                   & ~YW'(mtl_pkg::ALIGN_TEXELS - 1);
        side       = x_side + YW'(half2);
        width_span = ((r_n > LW'(1)) && (side > YW'(w_e))) ? side : YW'(w_e);
        pitch      = (PW'({width_span, 1'b0}) + PW'(mtl_pkg::PITCH_ALIGN - 1))
                   & ~PW'(mtl_pkg::PITCH_ALIGN - 1);
    end

    // per-level datapath
    always_comb begin
        rows     = (YW'(r_ch) + YW'(mtl_pkg::ALIGN_ROWS - 1)) & ~YW'(mtl_pkg::ALIGN_ROWS - 1);
        y_end    = r_y + rows;
        tot_next = (y_end > r_total) ? y_end : r_total;
        prod     = mtl_pkg::PROD_W'(r_y) * mtl_pkg::PROD_W'(r_pitch);
        offset   = prod + mtl_pkg::PROD_W'({r_x, 1'b0});
        is_last  = (LW'(r_lvl + 1'b1) == r_n);
    end

    assign out_free      = !r_out_valid || o_res.ready;
    assign cond.in_valid = i_req.valid;
    assign cond.req_ok   = req_ok;
    assign cond.more     = !is_last;
    assign cond.out_free = out_free;

    assign fire_lvl = ctrl.emit_lvl && seq_go;
    assign fire_ref = ctrl.emit_ref && seq_go;

    // take nothing while reset is held
    assign i_req.ready = ctrl.take_in && i_rst_n;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_lvl || fire_ref) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.take_in && i_req.valid) begin
            r_w <= i_req.data.map_width;
            r_h <= i_req.data.map_height;
            r_n <= i_req.data.level_count;
        end
        if (ctrl.setup) begin
            r_pitch <= pitch;
            r_x     <= '0;
            r_y     <= '0;
            r_total <= '0;
            r_lvl   <= '0;
            r_ch    <= r_h[EW-1:0];
        end
        if (fire_lvl) begin
            r_out.ok                <= 1'b1;
            r_out.level_index       <= r_lvl;
            r_out.level_byte_offset <= offset[mtl_pkg::OFF_W-1:0];
            r_out.row_pitch         <= r_pitch;
            r_out.total_rows        <= is_last ? tot_next[mtl_pkg::ROWS_W-1:0] : '0;
            r_out.last              <= is_last;
            // advance to the next level; level 1 opens the right-hand column
            r_lvl   <= LW'(r_lvl + 1'b1);
            r_ch    <= (r_ch > EW'(1)) ? (r_ch >> 1) : EW'(1);
            r_total <= tot_next;
            if (r_lvl == LW'(1)) begin
                r_x <= x_side;
            end else begin
                r_y <= y_end;
            end
        end else if (fire_ref) begin
            r_out <= '{1'b0, '0, '0, '0, '0, 1'b1};
        end
    end

    a_one_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item taken before the request finished");

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_lvl |-> (r_lvl < r_n))
        else $error("level step ran past the requested level count");

    a_refuse_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.ok) |-> (o_res.data.last && o_res.data.row_pitch == '0))
        else $error("refused item must be a lone last item with zero pitch");

    a_pitch_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.ok)
            |-> (o_res.data.row_pitch[5:0] == '0 && o_res.data.row_pitch != '0))
        else $error("row pitch not 64-byte aligned");

endmodule
